FILE: hdl/spg_pkg.sv
// Shared types and constants for the spaced position generator.
// No dependencies; imported by every module of the block except spg_div.
package spg_pkg;

	localparam int MAX_POSITIONS_DEF = 64;
	localparam int POSITION_BITS_DEF = 16;
	localparam int SPACING_BITS      = 16;
	localparam int CFG_INDEX_BITS    = 1;
	localparam int CFG_DATA_BITS     = 16;

	localparam logic [SPACING_BITS-1:0] GAP_LIMIT_RESET = 16'd600;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SPACING_MODE = 1'b0,
		REG_GAP_LIMIT    = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		MODE_EVEN     = 1'b0,
		MODE_MAXIMISE = 1'b1
	} spacing_mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLASSIFY,
		S_DIV1,
		S_COUNT,
		S_DIV2,
		S_EMIT,
		S_ERROR
	} state_t;

	typedef struct packed {
		logic load;
		logic zero_run;
		logic div_go;
		logic div_sel_gaps;
		logic div1_take;
		logic div2_take;
		logic emit_step;
		logic emit_error;
	} spg_cmd_t;

	typedef struct packed {
		logic bad;
		logic span_zero;
		logic div_done;
		logic too_many;
		logic even_mode;
		logic slot_free;
		logic last_word;
	} spg_status_t;

endpackage

FILE: hdl/spg_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the datapath for every division of a request.
module spg_div #(
	parameter int DIVIDEND_BITS = 16,
	parameter int DIVISOR_BITS  = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [DIVIDEND_BITS-1:0] dividend,
	input  logic [DIVISOR_BITS-1:0]  divisor,
	output logic                     done,
	output logic [DIVIDEND_BITS-1:0] quotient,
	output logic [DIVISOR_BITS-1:0]  remainder
);

	localparam int CW = $clog2(DIVIDEND_BITS + 1);

	logic [DIVIDEND_BITS-1:0] quo_q;
	logic [DIVISOR_BITS-1:0]  rem_q;
	logic [CW-1:0]            cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [DIVISOR_BITS:0]    shifted;
	logic [DIVISOR_BITS:0]    diff;
	logic                     fits;

	assign shifted = {rem_q, quo_q[DIVIDEND_BITS-1]};
	assign diff    = shifted - {1'b0, divisor};
	assign fits    = shifted >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(DIVIDEND_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_BITS-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: hdl/spg_datapath.sv
// Datapath: configuration registers, request registers, position stepping
// and the output register. Depends on spg_pkg and spg_div.
module spg_datapath
	import spg_pkg::*;
#(
	parameter int MAX_POSITIONS = MAX_POSITIONS_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  spg_cmd_t                  cmd,
	output spg_status_t               sts,
	input  logic [POSITION_BITS-1:0]  start_position,
	input  logic [POSITION_BITS-1:0]  end_position,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic [POSITION_BITS-1:0]  position,
	output logic                      last,
	output logic                      error,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int PB = POSITION_BITS;
	localparam int IW = $clog2(MAX_POSITIONS);
	localparam int SW = ((PB > SPACING_BITS) ? PB : SPACING_BITS) + 1;

	spacing_mode_t           mode_q;
	logic [SPACING_BITS-1:0] ms_q;
	logic [PB-1:0]           start_q;
	logic [PB-1:0]           end_q;
	logic [PB-1:0]           pos_q;
	logic [IW-1:0]           idx_q;
	logic [IW-1:0]           nlast_q;
	logic                    too_many_q;
	logic [SPACING_BITS-1:0] rem1_q;
	logic [PB-1:0]           step_q;
	logic [SPACING_BITS-1:0] frac_inc_q;
	logic [SPACING_BITS-1:0] frac_q;
	logic                    out_valid_q;
	logic [PB-1:0]           position_q;
	logic                    last_q;
	logic                    error_q;

	logic [PB-1:0]           span;
	logic [SPACING_BITS-1:0] divisor;
	logic                    div_done;
	logic [PB-1:0]           quo;
	logic [SPACING_BITS-1:0] rem;
	logic [PB:0]             gaps;
	logic [SPACING_BITS:0]   frac_sum;
	logic                    carry;
	logic [SPACING_BITS-1:0] frac_next;
	logic [PB:0]             pos_even;
	logic [SW-1:0]           pos_ms;
	logic [SPACING_BITS:0]   left_sum;
	logic [SW-1:0]           pos_half;
	logic [IW:0]             idx_inc;
	logic [IW:0]             idx_inc2;
	logic                    next_last;
	logic                    next_second;
	logic [PB-1:0]           pos_next;

	assign span    = end_q - start_q;
	assign divisor = cmd.div_sel_gaps ? SPACING_BITS'(nlast_q) : ms_q;

	spg_div #(
		.DIVIDEND_BITS(PB),
		.DIVISOR_BITS (SPACING_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (span),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quo),
		.remainder(rem)
	);

	assign gaps = {1'b0, quo} + (PB+1)'(rem != '0);

	assign frac_sum  = {1'b0, frac_q} + {1'b0, frac_inc_q};
	assign carry     = frac_sum >= (SPACING_BITS+1)'(nlast_q);
	assign frac_next = carry ? SPACING_BITS'(frac_sum - (SPACING_BITS+1)'(nlast_q))
	                         : frac_sum[SPACING_BITS-1:0];
	assign pos_even  = {1'b0, pos_q} + {1'b0, step_q} + (PB+1)'(carry);
	assign pos_ms    = SW'(pos_q) + SW'(ms_q);
	assign left_sum  = {1'b0, ms_q} + {1'b0, rem1_q};
	assign pos_half  = SW'(pos_q) + SW'(left_sum[SPACING_BITS:1]);

	assign idx_inc     = {1'b0, idx_q} + (IW+1)'(1);
	assign idx_inc2    = {1'b0, idx_q} + (IW+1)'(2);
	assign next_last   = idx_inc == {1'b0, nlast_q};
	assign next_second = (idx_inc2 == {1'b0, nlast_q}) && (rem1_q != '0);

	always_comb begin
		priority if (next_last) begin
			pos_next = end_q;
		end else if (mode_q == MODE_EVEN) begin
			pos_next = pos_even[PB-1:0];
		end else if (next_second) begin
			pos_next = pos_half[PB-1:0];
		end else begin
			pos_next = pos_ms[PB-1:0];
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_EVEN;
			ms_q   <= GAP_LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SPACING_MODE: mode_q <= spacing_mode_t'(cfg_data[0]);
				REG_GAP_LIMIT:    ms_q   <= cfg_data[SPACING_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			nlast_q     <= '0;
			too_many_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.emit_step) begin
				idx_q <= idx_inc[IW-1:0];
			end
			if (cmd.zero_run) begin
				nlast_q <= '0;
			end else if (cmd.div1_take) begin
				nlast_q    <= gaps[IW-1:0];
				too_many_q <= gaps >= (PB+1)'(MAX_POSITIONS);
			end
			if (cmd.emit_step || cmd.emit_error) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_q <= start_position;
			end_q   <= end_position;
			pos_q   <= start_position;
			frac_q  <= '0;
		end else if (cmd.emit_step) begin
			pos_q  <= pos_next;
			frac_q <= frac_next;
		end
		if (cmd.div1_take) begin
			rem1_q <= rem;
		end
		if (cmd.div2_take) begin
			step_q     <= quo;
			frac_inc_q <= rem;
		end
		if (cmd.emit_step) begin
			position_q <= pos_q;
			last_q     <= idx_q == nlast_q;
			error_q    <= 1'b0;
		end else if (cmd.emit_error) begin
			position_q <= '0;
			last_q     <= 1'b1;
			error_q    <= 1'b1;
		end
	end

	assign sts.bad       = (start_q > end_q) || (ms_q == '0);
	assign sts.span_zero = start_q == end_q;
	assign sts.div_done  = div_done;
	assign sts.too_many  = too_many_q;
	assign sts.even_mode = mode_q == MODE_EVEN;
	assign sts.slot_free = !out_valid_q || out_ready;
	assign sts.last_word = idx_q == nlast_q;

	assign out_valid = out_valid_q;
	assign position  = position_q;
	assign last      = last_q;
	assign error     = error_q;

endmodule

FILE: hdl/spg_ctrl.sv
// Controller state machine: sequences checks, divisions and the emit run.
// Depends on spg_pkg; drives the datapath through spg_cmd_t.
module spg_ctrl
	import spg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  spg_status_t sts,
	output spg_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CLASSIFY;
				end
			end
			S_CLASSIFY: begin
				priority if (sts.bad) begin
					state_d = S_ERROR;
				end else if (sts.span_zero) begin
					cmd.zero_run = 1'b1;
					state_d      = S_EMIT;
				end else begin
					cmd.div_go = 1'b1;
					state_d    = S_DIV1;
				end
			end
			S_DIV1: begin
				if (sts.div_done) begin
					cmd.div1_take = 1'b1;
					state_d       = S_COUNT;
				end
			end
			S_COUNT: begin
				priority if (sts.too_many) begin
					state_d = S_ERROR;
				end else if (sts.even_mode) begin
					cmd.div_go       = 1'b1;
					cmd.div_sel_gaps = 1'b1;
					state_d          = S_DIV2;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_DIV2: begin
				cmd.div_sel_gaps = 1'b1;
				if (sts.div_done) begin
					cmd.div2_take = 1'b1;
					state_d       = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.slot_free) begin
					cmd.emit_step = 1'b1;
					if (sts.last_word) begin
						state_d = S_IDLE;
					end
				end
			end
			S_ERROR: begin
				if (sts.slot_free) begin
					cmd.emit_error = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

FILE: hdl/spaced_position_generator.sv
// Sequence: a check of the request, one division on the shared divider and a counting step;
// in even mode a second division follows, in maximise mode the emit run follows directly.
// A zero span skips the divisions; a bad request or too many positions gives one error word.
// Throughput: one request at a time, one word per cycle while out_ready is high; the next
// request is taken once the last word of its run has been emitted.
// Reset: asynchronous, active low; clears control state, mode to even, gap limit 600.
module spaced_position_generator
	import spg_pkg::*;
#(
	parameter int MAX_POSITIONS = MAX_POSITIONS_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [POSITION_BITS-1:0]  start_position,
	input  logic [POSITION_BITS-1:0]  end_position,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [POSITION_BITS-1:0]  position,
	output logic                      last,
	output logic                      error,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	spg_cmd_t    cmd;
	spg_status_t sts;

	spg_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	spg_datapath #(
		.MAX_POSITIONS(MAX_POSITIONS),
		.POSITION_BITS(POSITION_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.start_position(start_position),
		.end_position  (end_position),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.position      (position),
		.last          (last),
		.error         (error),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

endmodule

FILE: hdl/spg_checker.sv
// Port-level checks for the spaced position generator, bound to the top level.
// Depends on spg_pkg.
module spg_assertions
	import spg_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [POSITION_BITS-1:0] position,
	input logic                     last,
	input logic                     error
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(position) && $stable(last)
			&& $stable(error))
		else $error("result word changed while stalled");

	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> last && (position == '0))
		else $error("error word must be final with zero position");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while one is in progress");

	a_run_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("request taken before its run finished");

endmodule

bind spaced_position_generator spg_assertions #(
	.POSITION_BITS(POSITION_BITS)
) u_spg_assertions (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.position (position),
	.last     (last),
	.error    (error)
);
